// ===== design/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash table package
// Shared types, codes and default sizes of the chained hash table.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int KEY_W            = 31;
    localparam int ACT_W            = 2;
    localparam int CFG_W            = 7;
    localparam int DEF_MAX_BUCKETS  = 64;
    localparam int DEF_SLOTS        = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic hit;
        logic overflow;
    } t_resp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_FRD,
        ST_DECIDE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

// ===== design/hts_mod.sv =====
// ----------------------------------------------------------------------------
// Key remainder unit
// Restoring remainder of a key by the bucket count, one key bit per cycle.
// ----------------------------------------------------------------------------
module hts_mod #(
    parameter int MAX_BUCKETS = hts_pkg::DEF_MAX_BUCKETS,
    parameter int DIV_W       = $clog2(MAX_BUCKETS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [hts_pkg::KEY_W-1:0] i_key,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [DIV_W-1:0]        o_rem
);
    import hts_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [KEY_W-1:0] r_k;

    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_k[KEY_W-1]};
        w_ge    = w_trial >= {1'b0, i_divisor};
        if (w_ge) begin
            n_rem = DIV_W'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_k   <= i_key;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_k   <= {r_k[KEY_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== design/hash_table_separate_chaining.sv =====
// ----------------------------------------------------------------------------
// Chained hash table
// Insert, find and remove of 31-bit keys in buckets of fixed slot count.
// ----------------------------------------------------------------------------
// Each input word carries an action and a key; each one yields exactly one
// output word with hit and overflow flags. Both channels use valid and ready.
// The bucket count register is written through i_cfg_we and i_cfg_wdata; the
// user must write it only while the table is idle, which the block itself does
// not enforce. Zero acts as one and values above MAX_BUCKETS saturate.
// One word is processed at a time. The key remainder is formed one key bit
// per cycle, then the bucket fill count is fetched. An insert ends there; a
// find or remove scans one slot per cycle, and a remove then moves each later
// slot down by one per cycle.
// After reset the fill counts of all MAX_BUCKETS buckets are cleared in a
// pass during which no input word is taken; the bucket count returns to 64.
// The result sits in an output register; the next word is accepted while it
// waits, but its own result waits until the receiver has taken the previous.
// ----------------------------------------------------------------------------
module hash_table_separate_chaining #(
    parameter int MAX_BUCKETS      = hts_pkg::DEF_MAX_BUCKETS,
    parameter int SLOTS_PER_BUCKET = hts_pkg::DEF_SLOTS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  hts_pkg::t_req            i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output hts_pkg::t_resp           o_out_data,
    input  logic                     i_cfg_we,
    input  logic [hts_pkg::CFG_W-1:0] i_cfg_wdata
);
    import hts_pkg::*;

    localparam int DIV_W   = $clog2(MAX_BUCKETS + 1);
    localparam int BKT_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DEPTH   = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = $clog2(SLOTS_PER_BUCKET + 1);

    logic [KEY_W-1:0]  store_mem [DEPTH];
    logic [FILL_W-1:0] fill_mem  [MAX_BUCKETS];

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [BKT_W-1:0]  r_clr;
    logic [ACT_W-1:0]  r_act;
    logic [KEY_W-1:0]  r_key;
    logic [BKT_W-1:0]  r_bucket;
    logic [ADDR_W-1:0] r_base;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic [FILL_W-1:0] r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic              r_hit, n_hit;
    logic              r_ovf, n_ovf;
    logic              r_out_valid;
    t_resp             r_out;
    logic [KEY_W-1:0]  r_rdata;
    logic [FILL_W-1:0] r_fill_q;

    logic [DIV_W-1:0]  w_div;
    logic              w_accept;
    logic              w_mod_done;
    logic [DIV_W-1:0]  w_rem;
    logic              w_match;
    logic              w_scan_issue;
    logic              w_shift_issue;
    logic              w_load_out;

    logic              store_we;
    logic [ADDR_W-1:0] store_waddr;
    logic [KEY_W-1:0]  store_wdata;
    logic [ADDR_W-1:0] store_raddr;
    logic              fill_we;
    logic [BKT_W-1:0]  fill_waddr;
    logic [FILL_W-1:0] fill_wdata;

    always_comb begin
        if (r_cfg == '0) begin
            w_div = DIV_W'(1);
        end else if (32'(r_cfg) > MAX_BUCKETS) begin
            w_div = DIV_W'(MAX_BUCKETS);
        end else begin
            w_div = DIV_W'(r_cfg);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    hts_mod #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .DIV_W       (DIV_W)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_key     (i_in_data.key),
        .i_divisor (w_div),
        .o_done    (w_mod_done),
        .o_rem     (w_rem)
    );

    assign w_match       = r_pend && (r_rdata == r_key);
    assign w_scan_issue  = r_idx < r_fill_q;
    assign w_shift_issue = ({1'b0, r_idx} + 1'b1) < {1'b0, r_fill_q};
    assign w_load_out    = (r_state == ST_RESP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == BKT_W'(MAX_BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_mod_done) begin
                    n_state = ST_FRD;
                end
            end
            ST_FRD: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_act == ACT_FIND || r_act == ACT_REMOVE) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_state = (r_act == ACT_REMOVE) ? ST_SHIFT : ST_RESP;
                end else if (!w_scan_issue) begin
                    n_state = ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (!w_shift_issue) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_ovf       = r_ovf;
        store_we    = 1'b0;
        store_waddr = r_base + ADDR_W'(r_pidx);
        store_wdata = r_rdata;
        store_raddr = r_base + ADDR_W'(r_idx);
        fill_we     = 1'b0;
        fill_waddr  = r_bucket;
        fill_wdata  = r_fill_q - 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
            end
            ST_IDLE: begin
                n_hit = 1'b0;
                n_ovf = 1'b0;
            end
            ST_DECIDE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                if (r_act == ACT_INSERT) begin
                    if (r_fill_q < FILL_W'(SLOTS_PER_BUCKET)) begin
                        store_we    = 1'b1;
                        store_waddr = r_base + ADDR_W'(r_fill_q);
                        store_wdata = r_key;
                        fill_we     = 1'b1;
                        fill_wdata  = r_fill_q + 1'b1;
                        n_hit       = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_hit  = (r_act == ACT_FIND);
                    n_idx  = r_pidx;
                    n_pend = 1'b0;
                end else if (w_scan_issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pidx = r_idx;
                    n_pend = 1'b1;
                end
            end
            ST_SHIFT: begin
                store_raddr = r_base + ADDR_W'(r_idx) + ADDR_W'(1);
                store_we    = r_pend;
                if (w_shift_issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pidx = r_idx;
                    n_pend = 1'b1;
                end else begin
                    fill_we = 1'b1;
                    n_hit   = 1'b1;
                end
            end
            ST_MOD, ST_FRD, ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cfg       <= CFG_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_pend <= n_pend;
        r_hit  <= n_hit;
        r_ovf  <= n_ovf;
        if (w_accept) begin
            r_act <= i_in_data.action;
            r_key <= i_in_data.key;
        end
        if (w_mod_done) begin
            r_bucket <= BKT_W'(w_rem);
        end
        if (r_state == ST_FRD) begin
            r_base <= ADDR_W'(r_bucket) * ADDR_W'(SLOTS_PER_BUCKET);
        end
        if (w_load_out) begin
            r_out.hit      <= r_hit;
            r_out.overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        r_rdata <= store_mem[store_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_q <= fill_mem[r_bucket];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_excl_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.overflow))
        else $error("hit and overflow raised together");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == ST_MOD))
        else $error("remainder finished outside its wait state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> (r_fill_q <= FILL_W'(SLOTS_PER_BUCKET)))
        else $error("bucket fill count beyond slot count");

    a_ready_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_out_valid && o_in_ready))
        else $error("result register not loaded on completion");

endmodule

// ===== tb/tb_hash_table_separate_chaining.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table testbench
// Sends insert, find, remove and unused-action words over several bucket counts and checks
// every hit and overflow flag against a behavioural copy of the buckets.
// ----------------------------------------------------------------------------
module tb_hash_table_separate_chaining;
    import hts_pkg::*;

    localparam int NBUCKETS    = DEF_MAX_BUCKETS;
    localparam int NSLOTS      = DEF_SLOTS;
    localparam int IDLE_PCT    = 23;
    localparam int SETTLE_CYC  = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYC    = 300;
    localparam int CALM_LO     = 600;
    localparam int CALM_HI     = 800;
    localparam int PHASE_ITEMS = 111;
    localparam int POOL_SZ     = 16;
    localparam int DRAIN_IDX   = 50;

    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic             is_cfg;
        logic             drain;
        logic [CFG_W-1:0] cfg_val;
        t_req             req;
    } t_job;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_req             in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_resp            out_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = CFG_RESET;

    logic [KEY_W-1:0] key_store [NBUCKETS][NSLOTS];
    int unsigned      fill_cnt  [NBUCKETS];
    logic [CFG_W-1:0] bucket_cnt = CFG_RESET;
    logic [KEY_W-1:0] key_pool  [POOL_SZ];

    logic [CFG_W-1:0] phase_cfg [12] = '{7'd0, 7'd1, 7'd127, 7'd3, 7'd64, 7'd5,
                                         7'd17, 7'd100, 7'd2, 7'd42, 7'd1, 7'd64};

    t_job  job_q[$];
    t_resp resp_expect_q[$];

    int sent_cnt  = 0;
    int got_cnt   = 0;
    int err_cnt   = 0;
    int quiet_cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    hash_table_separate_chaining u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned eff_buckets(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > NBUCKETS) return NBUCKETS;
        return int'(v);
    endfunction

    function automatic t_resp hash_apply(t_req req);
        int unsigned b;
        int unsigned n;
        int unsigned pos;
        t_resp       r;
        b   = req.key % eff_buckets(bucket_cnt);
        n   = fill_cnt[b];
        pos = n;
        r   = '0;
        for (int unsigned i = 0; i < n; i++) begin
            if (pos == n && key_store[b][i] == req.key) pos = i;
        end
        case (req.action)
            ACT_INSERT: begin
                if (n < NSLOTS) begin
                    key_store[b][n] = req.key;
                    fill_cnt[b]     = n + 1;
                    r.hit           = 1'b1;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            ACT_FIND: begin
                r.hit = (pos < n);
            end
            ACT_REMOVE: begin
                if (pos < n) begin
                    for (int unsigned i = pos; i + 1 < n; i++) begin
                        key_store[b][i] = key_store[b][i + 1];
                    end
                    fill_cnt[b] = n - 1;
                    r.hit       = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void queue_req(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                      logic drain);
        t_job j;
        j            = '0;
        j.drain      = drain;
        j.req.action = act;
        j.req.key    = key;
        job_q        = {job_q, j};
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 40) return ACT_INSERT;
        if (p < 70) return ACT_FIND;
        return ACT_REMOVE;
    endfunction

    // Most keys of a phase fall into a few buckets so that they fill, overflow
    // and are emptied again.
    task automatic queue_phase(input logic [CFG_W-1:0] cfg_val);
        t_job        j;
        int unsigned d;
        int unsigned hot;
        int unsigned p;
        j         = '0;
        j.is_cfg  = 1'b1;
        j.cfg_val = cfg_val;
        job_q     = {job_q, j};
        d   = eff_buckets(cfg_val);
        hot = (d < 4) ? d : 4;
        foreach (key_pool[k]) begin
            if ($urandom_range(0, 3) == 0) begin
                key_pool[k] = KEY_W'($urandom);
            end else begin
                key_pool[k] = KEY_W'($urandom_range(0, 24'hFF_FFFF) * d
                                     + $urandom_range(0, hot - 1));
            end
        end
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            p = $urandom_range(0, 99);
            if (p < 5) begin
                queue_req(ACT_NOP, KEY_W'($urandom), i == DRAIN_IDX);
            end else if (p < 15) begin
                queue_req(pick_action(), KEY_W'($urandom), i == DRAIN_IDX);
            end else begin
                queue_req(pick_action(), key_pool[$urandom_range(0, POOL_SZ - 1)],
                          i == DRAIN_IDX);
            end
        end
    endtask

    always @(posedge clk) begin : driver
        logic             valid_nxt;
        t_req             data_nxt;
        logic             we_nxt;
        logic [CFG_W-1:0] wdata_nxt;
        t_job             job;
        logic             calm;
        valid_nxt = in_valid;
        data_nxt  = in_data;
        we_nxt    = 1'b0;
        wdata_nxt = cfg_wdata;
        calm      = (sent_cnt >= CALM_LO && sent_cnt < CALM_HI);
        if (!rst_n) begin
            valid_nxt = 1'b0;
            quiet_cyc = 0;
        end else begin
            if (in_valid && in_ready) begin
                resp_expect_q = {resp_expect_q, hash_apply(in_data)};
                sent_cnt++;
                valid_nxt = 1'b0;
            end
            if (resp_expect_q.size() == 0 && !in_valid) begin
                quiet_cyc++;
            end else begin
                quiet_cyc = 0;
            end
            if (!valid_nxt && job_q.size() != 0) begin
                job = job_q[0];
                if (job.is_cfg) begin
                    if (quiet_cyc >= SETTLE_CYC) begin
                        void'(job_q.pop_front());
                        we_nxt     = 1'b1;
                        wdata_nxt  = job.cfg_val;
                        bucket_cnt = job.cfg_val;
                        quiet_cyc  = 0;
                    end
                end else if (!(job.drain && resp_expect_q.size() != 0)
                             && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    void'(job_q.pop_front());
                    valid_nxt = 1'b1;
                    data_nxt  = job.req;
                end
            end
        end
        in_valid  <= valid_nxt;
        in_data   <= data_nxt;
        cfg_we    <= we_nxt;
        cfg_wdata <= wdata_nxt;
    end

    always @(posedge clk) begin : monitor
        logic  ready_nxt;
        t_resp want;
        if (!rst_n) begin
            ready_nxt = 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got_cnt++;
                if (resp_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected word hit %0b overflow %0b",
                                         out_data.hit, out_data.overflow));
                end else begin
                    want = resp_expect_q.pop_front();
                    if (out_data.hit !== want.hit || out_data.overflow !== want.overflow) begin
                        flag_error($sformatf(
                            "word %0d: hit exp %0b got %0b, overflow exp %0b got %0b",
                            got_cnt, want.hit, out_data.hit, want.overflow,
                            out_data.overflow));
                    end
                end
            end
            // A long hold while words are still offered fills the block up.
            if (hold_left != 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (!hold_done && got_cnt >= HOLD_AT && in_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = (got_cnt >= CALM_LO && got_cnt < CALM_HI)
                            || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
        out_ready <= ready_nxt;
    end

    initial begin
        for (int b = 0; b < NBUCKETS; b++) fill_cnt[b] = 0;

        queue_req(ACT_INSERT, 31'd0,          1'b0);
        queue_req(ACT_INSERT, 31'h7FFF_FFFF,  1'b0);
        queue_req(ACT_FIND,   31'h7FFF_FFFF,  1'b0);
        queue_req(ACT_FIND,   31'd64,         1'b0);
        queue_req(ACT_REMOVE, 31'd5,          1'b0);
        queue_req(ACT_NOP,    31'h2AAA_AAAA,  1'b0);
        queue_req(ACT_NOP,    31'h5555_5555,  1'b0);
        queue_req(ACT_INSERT, 31'd0,          1'b0);
        for (int k = 1; k <= 6; k++) queue_req(ACT_INSERT, KEY_W'(64 * k), 1'b0);
        queue_req(ACT_INSERT, 31'd448,        1'b0);
        queue_req(ACT_FIND,   31'd448,        1'b0);
        queue_req(ACT_REMOVE, 31'd0,          1'b0);
        queue_req(ACT_FIND,   31'd0,          1'b0);
        queue_req(ACT_REMOVE, 31'd0,          1'b0);
        queue_req(ACT_FIND,   31'd0,          1'b0);
        queue_req(ACT_REMOVE, 31'h7FFF_FFFF,  1'b0);
        queue_req(ACT_INSERT, 31'd448,        1'b0);
        queue_req(ACT_FIND,   31'd384,        1'b0);

        foreach (phase_cfg[p]) queue_phase(phase_cfg[p]);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() != 0 || in_valid || resp_expect_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        if (err_cnt == 0 && resp_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
